/* rtl/pgps_pkg.sv */
// pgps_pkg: shared widths, register indexes and controller/datapath bundles
// for the process grid partition search block; no dependencies
package pgps_pkg;

    localparam int CW      = 9;            // processor count and split width
    localparam int GW      = 12;           // grid size width
    localparam int NDIM    = 4;            // dimensions in hardware
    localparam int AREA_W  = 3 * GW;       // product of up to three grid sizes
    localparam int WT_W    = CW + 1;       // face count weight of one dimension
    localparam int TERM_W  = WT_W + AREA_W;
    localparam int ACC_W   = TERM_W + 3;   // full-precision cost
    localparam int COST_W  = 48;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 12;

    typedef enum logic [CFG_IW-1:0] {
        REG_NUM_DIMS  = 3'd0,
        REG_GRID_0    = 3'd1,
        REG_GRID_1    = 3'd2,
        REG_GRID_2    = 3'd3,
        REG_GRID_3    = 3'd4,
        REG_PERIODIC  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic load;
        logic area_step;
        logic scan_div;
        logic scan_store;
        logic prod1;
        logic prod2;
        logic prod_div;
        logic cand0_set;
        logic cost_mul;
        logic cost_add;
        logic best_update;
        logic odo_step;
        logic odo_latch;
    } t_cmd;

    typedef struct packed {
        logic area_last;
        logic div_busy;
        logic rem_zero;
        logic scan_last;
        logic prod_over;
        logic cost_last;
        logic odo_end;
    } t_stat;

endpackage

/* rtl/process_grid_partition_search_core.sv */
// process_grid_partition_search_core: top level of the grid partition search
// depends on pgps_pkg, pgps_ctrl, pgps_datapath
//
//  channel   | handshake                 | beat
//  ----------+---------------------------+----------------------------------------
//  command   | i_start / o_busy          | i_processor_count
//  result    | o_done (one-cycle strobe) | o_split_0..3, o_best_cost
//  config    | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one count at a time; after the area setup and a scan of 1..P for divisors,
// each candidate is dropped if its product is above P, else divided on the
// shared 9-step divider and dropped if not a divisor, else scored by the
// 4-step cost accumulate
// synchronous active-low reset; the divisor ram needs no clearing
// o_done pulses in the last cycle of o_busy; results hold until the next count
module process_grid_partition_search_core import pgps_pkg::*; #(
    parameter int MAX_PROCS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CW-1:0]     i_processor_count,
    output logic              o_busy,
    output logic              o_done,
    output logic [CW-1:0]     o_split_0,
    output logic [CW-1:0]     o_split_1,
    output logic [CW-1:0]     o_split_2,
    output logic [CW-1:0]     o_split_3,
    output logic [COST_W-1:0] o_best_cost,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);
    localparam int PMAX = (MAX_PROCS < 511) ? MAX_PROCS : 511;

    t_cmd          cmd;
    t_stat         stat;
    logic          busy;
    logic [CW-1:0] split [NDIM];

    pgps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    pgps_datapath #(.PMAX(PMAX)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_count     (i_processor_count),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_split     (split),
        .o_cost      (o_best_cost)
    );

    assign o_busy      = busy;
    assign o_cfg_ready = 1'b1;
    assign o_split_0   = split[0];
    assign o_split_1   = split[1];
    assign o_split_2   = split[2];
    assign o_split_3   = split[3];
endmodule

/* rtl/pgps_ram.sv */
// pgps_ram: generic single write port, single read port ram with registered read
// no dependencies
module pgps_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/pgps_div.sv */
// pgps_div: restoring divider, one quotient bit per cycle
// depends on pgps_pkg
module pgps_div import pgps_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [CW-1:0] i_dividend,
    input  logic [CW-1:0] i_divisor,
    output logic          o_busy,
    output logic [CW-1:0] o_quotient,
    output logic [CW-1:0] o_remainder
);
    localparam int NW = $clog2(CW + 1);

    logic [NW-1:0] r_cnt;
    logic          r_busy;
    logic [CW-1:0] r_quo, r_rem, r_dvs;
    logic [CW:0]   sh;

    assign sh = {r_rem, r_quo[CW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= NW'(CW);
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            if (sh >= {1'b0, r_dvs}) begin
                r_rem <= CW'(sh - {1'b0, r_dvs});
                r_quo <= {r_quo[CW-2:0], 1'b1};
            end else begin
                r_rem <= sh[CW-1:0];
                r_quo <= {r_quo[CW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == NW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule

/* rtl/pgps_datapath.sv */
// pgps_datapath: config registers, divisor list, candidate odometer and cost unit
// depends on pgps_pkg, pgps_div, pgps_ram
module pgps_datapath import pgps_pkg::*; #(
    parameter int PMAX = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [CFG_DW-1:0]   i_cfg_data,
    input  logic [CW-1:0]       i_count,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    output logic [CW-1:0]       o_split [NDIM],
    output logic [COST_W-1:0]   o_cost
);
    localparam int RA = (PMAX > 1) ? $clog2(PMAX) : 1;
    localparam int NW = $clog2(PMAX + 1);

    logic [2:0]        r_num_dims;
    logic [GW-1:0]     r_grid [NDIM];
    logic [NDIM-1:0]   r_pmask;

    logic [CW-1:0]     r_procs;
    logic [2:0]        r_dims;
    logic [AREA_W-1:0] r_area [NDIM];
    logic [1:0]        r_ad, r_ae;
    logic [CW-1:0]     r_v;
    logic [NW-1:0]     r_ndiv;
    logic [CW-1:0]     r_cand [NDIM];
    logic [NW-1:0]     r_idx [1:NDIM-1];
    logic [3*CW-1:0]   r_prod;
    logic [1:0]        r_cd;
    logic [TERM_W-1:0] r_term;
    logic [ACC_W-1:0]  r_acc, r_best_cost;
    logic [CW-1:0]     r_best [NDIM];
    logic              r_first;
    logic [1:0]        r_odo_d;

    logic [CW-1:0]     sat_count;
    logic [2:0]        dims_eff;
    logic              div_start, div_busy;
    logic [CW-1:0]     div_a, div_b, quo, rem;
    logic              ram_we;
    logic [RA-1:0]     ram_raddr;
    logic [CW-1:0]     ram_rdata;
    logic              odo_found;
    logic [1:0]        odo_sel;
    logic [WT_W-1:0]   weight;

    always_comb begin
        sat_count = i_count;
        if (i_count == '0) begin
            sat_count = CW'(1);
        end else if ({1'b0, i_count} > (CW + 1)'(PMAX)) begin
            sat_count = CW'(PMAX);
        end
        dims_eff = r_num_dims;
        if (r_num_dims == 3'd0) begin
            dims_eff = 3'd1;
        end else if (r_num_dims > 3'(NDIM)) begin
            dims_eff = 3'(NDIM);
        end
    end

    // lowest in-use dimension from 1 up whose index can still advance
    always_comb begin
        odo_found = 1'b0;
        odo_sel   = 2'd1;
        for (int d = NDIM - 1; d >= 1; d--) begin
            if (3'(d) < r_dims && (r_idx[d] + 1'b1) < r_ndiv) begin
                odo_found = 1'b1;
                odo_sel   = 2'(d);
            end
        end
    end

    assign ram_raddr = RA'(r_idx[odo_sel] + 1'b1);
    assign weight    = r_pmask[r_cd] ? {r_cand[r_cd], 1'b0}
                                     : {CW'(r_cand[r_cd] - 1'b1), 1'b0};

    assign div_start = i_cmd.scan_div | i_cmd.prod_div;
    assign div_a     = r_procs;
    assign div_b     = i_cmd.scan_div ? r_v : r_prod[CW-1:0];
    assign ram_we    = i_cmd.scan_store && (rem == '0);

    pgps_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_a),
        .i_divisor   (div_b),
        .o_busy      (div_busy),
        .o_quotient  (quo),
        .o_remainder (rem)
    );

    pgps_ram #(.WIDTH(CW), .DEPTH(PMAX)) u_divisors (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (RA'(r_ndiv)),
        .i_wdata (r_v),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= 3'd1;
            r_pmask    <= '0;
            for (int d = 0; d < NDIM; d++) begin
                r_grid[d] <= GW'(1);
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_NUM_DIMS: r_num_dims <= i_cfg_data[2:0];
                REG_GRID_0:   r_grid[0]  <= i_cfg_data[GW-1:0];
                REG_GRID_1:   r_grid[1]  <= i_cfg_data[GW-1:0];
                REG_GRID_2:   r_grid[2]  <= i_cfg_data[GW-1:0];
                REG_GRID_3:   r_grid[3]  <= i_cfg_data[GW-1:0];
                REG_PERIODIC: r_pmask    <= i_cfg_data[NDIM-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_procs <= sat_count;
            r_dims  <= dims_eff;
            r_ad    <= '0;
            r_ae    <= '0;
            r_v     <= CW'(1);
            r_ndiv  <= '0;
            r_first <= 1'b1;
            r_cand[0] <= sat_count;
            for (int d = 0; d < NDIM; d++) begin
                r_area[d] <= AREA_W'(1);
            end
            for (int d = 1; d < NDIM; d++) begin
                r_cand[d] <= CW'(1);
                r_idx[d]  <= '0;
            end
        end
        if (i_cmd.area_step) begin
            if (r_ae != r_ad && 3'(r_ae) < r_dims) begin
                r_area[r_ad] <= AREA_W'(r_area[r_ad] * r_grid[r_ae]);
            end
            {r_ad, r_ae} <= {r_ad, r_ae} + 1'b1;
        end
        if (i_cmd.scan_store) begin
            if (rem == '0) begin
                r_ndiv <= r_ndiv + 1'b1;
            end
            r_v <= r_v + 1'b1;
        end
        if (i_cmd.prod1) begin
            r_prod <= (3*CW)'(r_cand[1] * r_cand[2]);
        end
        if (i_cmd.prod2) begin
            r_prod <= (3*CW)'(r_prod[2*CW-1:0] * r_cand[3]);
        end
        if (i_cmd.cand0_set) begin
            r_cand[0] <= quo;
            r_acc     <= '0;
            r_cd      <= '0;
        end
        if (i_cmd.cost_mul) begin
            r_term <= (3'(r_cd) < r_dims) ? TERM_W'(weight * r_area[r_cd]) : '0;
        end
        if (i_cmd.cost_add) begin
            r_acc <= r_acc + ACC_W'(r_term);
            r_cd  <= r_cd + 1'b1;
        end
        if (i_cmd.best_update) begin
            r_first <= 1'b0;
            if (r_first || r_acc < r_best_cost) begin
                r_best_cost <= r_acc;
                for (int d = 0; d < NDIM; d++) begin
                    r_best[d] <= r_cand[d];
                end
            end
        end
        if (i_cmd.odo_step) begin
            r_odo_d <= odo_sel;
            for (int d = 1; d < NDIM; d++) begin
                if (2'(d) < odo_sel) begin
                    r_idx[d]  <= '0;
                    r_cand[d] <= CW'(1);
                end else if (2'(d) == odo_sel) begin
                    r_idx[d] <= r_idx[d] + 1'b1;
                end
            end
        end
        if (i_cmd.odo_latch) begin
            r_cand[r_odo_d] <= ram_rdata;
        end
    end

    assign o_stat.area_last = (r_ad == 2'd3) && (r_ae == 2'd3);
    assign o_stat.div_busy  = div_busy;
    assign o_stat.rem_zero  = (rem == '0);
    assign o_stat.scan_last = (r_v == r_procs);
    assign o_stat.prod_over = (r_prod > (3*CW)'(r_procs));
    assign o_stat.cost_last = (r_cd == 2'd3);
    assign o_stat.odo_end   = !odo_found;

    always_comb begin
        for (int d = 0; d < NDIM; d++) begin
            o_split[d] = r_best[d];
        end
    end
    assign o_cost = r_best_cost[COST_W-1:0];
endmodule

/* rtl/pgps_ctrl.sv */
// pgps_ctrl: sequencer for the partition search
// depends on pgps_pkg
module pgps_ctrl import pgps_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_done
);
    typedef enum logic [3:0] {
        S_IDLE, S_AREA, S_SCAN_DIV, S_SCAN_WAIT, S_SCAN_STORE, S_PROD1, S_PROD2,
        S_CHK, S_DIV_WAIT, S_QUO, S_COST_MUL, S_COST_ADD, S_BEST, S_ODO, S_LATCH,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_AREA;
                end
            end
            S_AREA: begin
                o_cmd.area_step = 1'b1;
                if (i_stat.area_last) n_state = S_SCAN_DIV;
            end
            S_SCAN_DIV: begin
                o_cmd.scan_div = 1'b1;
                n_state        = S_SCAN_WAIT;
            end
            S_SCAN_WAIT: begin
                if (!i_stat.div_busy) n_state = S_SCAN_STORE;
            end
            S_SCAN_STORE: begin
                o_cmd.scan_store = 1'b1;
                n_state = i_stat.scan_last ? S_PROD1 : S_SCAN_DIV;
            end
            S_PROD1: begin
                o_cmd.prod1 = 1'b1;
                n_state     = S_PROD2;
            end
            S_PROD2: begin
                o_cmd.prod2 = 1'b1;
                n_state     = S_CHK;
            end
            S_CHK: begin
                if (i_stat.prod_over) begin
                    n_state = S_ODO;
                end else begin
                    o_cmd.prod_div = 1'b1;
                    n_state        = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (!i_stat.div_busy) n_state = S_QUO;
            end
            S_QUO: begin
                if (i_stat.rem_zero) begin
                    o_cmd.cand0_set = 1'b1;
                    n_state         = S_COST_MUL;
                end else begin
                    n_state = S_ODO;
                end
            end
            S_COST_MUL: begin
                o_cmd.cost_mul = 1'b1;
                n_state        = S_COST_ADD;
            end
            S_COST_ADD: begin
                o_cmd.cost_add = 1'b1;
                n_state = i_stat.cost_last ? S_BEST : S_COST_MUL;
            end
            S_BEST: begin
                o_cmd.best_update = 1'b1;
                n_state           = S_ODO;
            end
            S_ODO: begin
                if (i_stat.odo_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.odo_step = 1'b1;
                    n_state        = S_LATCH;
                end
            end
            S_LATCH: begin
                o_cmd.odo_latch = 1'b1;
                n_state         = S_PROD1;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
endmodule

/* rtl/pgps_checker.sv */
// pgps_port_checks: port-level assertions for the partition search top level
// depends on pgps_pkg; bound to process_grid_partition_search_core
module pgps_port_checks import pgps_pkg::*; (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_start,
    input logic          o_busy,
    input logic          o_done,
    input logic [CW-1:0] o_split_0
);
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done longer than one cycle");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy) else $error("done while idle");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy) else $error("busy held after done");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_done)) else $error("start not taken");

    a_split_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_split_0 != '0)) else $error("zero split");
endmodule

bind process_grid_partition_search_core pgps_port_checks u_pgps_port_checks (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_start   (i_start),
    .o_busy    (o_busy),
    .o_done    (o_done),
    .o_split_0 (o_split_0)
);
